// ===== rtl/core/sorted_timer_queue_core_assert.svh =====
// ----------------------------------------------------------------------------
// Sorted timer queue assertion macros
// Shorthand for the clocked checks at the end of the core, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_TIMER_QUEUE_CORE_ASSERT_SVH
`define SORTED_TIMER_QUEUE_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STQ_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define STQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/stq_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted timer queue package
// Shared widths, operation and status codes, and controller/datapath structs.
// ----------------------------------------------------------------------------
`default_nettype none

package stq_pkg;

   localparam int TIME_W      = 32;
   localparam int COUNT_OUT_W = 5;
   localparam int STATUS_W    = 2;

   typedef enum logic {
      FUNC_INSERT = 1'b0,
      FUNC_DELETE = 1'b1
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE      = 2'd0,
      STATUS_ZERO      = 2'd1,
      STATUS_NOT_FOUND = 2'd2,
      STATUS_FULL      = 2'd3
   } status_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load_req;
      logic       compare;
      logic       commit;
      status_type result;
   } dp_cmd_type;

   // Flags from the datapath back to the controller.
   typedef struct packed {
      logic is_zero;
      logic is_full;
      logic is_delete;
      logic found;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== rtl/core/stq_ctrl.sv =====
// ----------------------------------------------------------------------------
// Sorted timer queue controller
// Sequences accept, compare and update, and owns the response valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module stq_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_ready,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   output      stq_pkg::dp_cmd_type   cmd,
   input  wire stq_pkg::dp_status_type dp_status
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COMPARE,
      ST_UPDATE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd.load_req = (state_ff == ST_IDLE) && req_valid;
      cmd.compare  = (state_ff == ST_COMPARE);
      cmd.commit   = (state_ff == ST_UPDATE) && out_free;
      priority if (dp_status.is_zero) begin
         cmd.result = stq_pkg::STATUS_ZERO;
      end else if (!dp_status.is_delete && dp_status.is_full) begin
         cmd.result = stq_pkg::STATUS_FULL;
      end else if (dp_status.is_delete && !dp_status.found) begin
         cmd.result = stq_pkg::STATUS_NOT_FOUND;
      end else begin
         cmd.result = stq_pkg::STATUS_DONE;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_COMPARE;
            end
         end
         ST_COMPARE: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (out_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/stq_datapath.sv =====
// ----------------------------------------------------------------------------
// Sorted timer queue datapath
// Chain of compare-and-shift cells holding the sorted values, plus the
// request capture and response registers.
// ----------------------------------------------------------------------------
`default_nettype none

module stq_datapath #(
   parameter int DEPTH = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_func,
   input  wire logic [stq_pkg::TIME_W-1:0]          req_time_value,
   input  wire stq_pkg::dp_cmd_type                 cmd,
   output      stq_pkg::dp_status_type              dp_status,
   output      logic [stq_pkg::STATUS_W-1:0]        rsp_status,
   output      logic [stq_pkg::COUNT_OUT_W-1:0]     rsp_entry_count,
   output      logic [stq_pkg::TIME_W-1:0]          rsp_earliest
);

   localparam int CW = $clog2(DEPTH + 1);

   logic                                 func_ff;
   logic [stq_pkg::TIME_W-1:0]           time_ff;
   logic [stq_pkg::TIME_W-1:0]           cell_ff [DEPTH];
   logic [stq_pkg::TIME_W-1:0]           cell_in [DEPTH];
   logic [DEPTH-1:0]                     lt_ff, lt_in;
   logic [DEPTH-1:0]                     eq_ff, eq_in;
   logic [CW-1:0]                        count_ff, count_in;
   logic [stq_pkg::STATUS_W-1:0]         rsp_status_ff;
   logic [stq_pkg::COUNT_OUT_W-1:0]      rsp_count_ff;
   logic [stq_pkg::TIME_W-1:0]           rsp_earliest_ff;
   logic [CW+stq_pkg::COUNT_OUT_W-1:0]   count_wide;
   logic                                 apply;
   logic                                 is_delete;

   assign is_delete = (func_ff == stq_pkg::FUNC_DELETE);
   assign apply     = cmd.commit && (cmd.result == stq_pkg::STATUS_DONE);

   assign dp_status.is_zero   = (time_ff == '0);
   assign dp_status.is_full   = (count_ff == CW'(DEPTH));
   assign dp_status.is_delete = is_delete;
   assign dp_status.found     = |eq_ff;

   // Empty slots hold zero, so a nonzero cell is an occupied one.
   generate
      for (genvar i = 0; i < DEPTH; i++) begin : g_cell
         logic occupied;
         logic [stq_pkg::TIME_W-1:0] ins_val;
         logic [stq_pkg::TIME_W-1:0] del_val;

         assign occupied = (cell_ff[i] != '0);
         assign lt_in[i] = occupied && (cell_ff[i] < time_ff);
         assign eq_in[i] = occupied && (cell_ff[i] == time_ff);

         if (i == 0) begin : g_first
            assign ins_val = lt_ff[i] ? cell_ff[i] : time_ff;
         end else begin : g_rest
            assign ins_val = lt_ff[i] ? cell_ff[i]
                           : (lt_ff[i-1] ? time_ff : cell_ff[i-1]);
         end

         // Cells at or past the first match pull in their upper neighbor.
         if (i == DEPTH - 1) begin : g_last
            assign del_val = (occupied && !lt_ff[i]) ? '0 : cell_ff[i];
         end else begin : g_inner
            assign del_val = (occupied && !lt_ff[i]) ? cell_ff[i+1] : cell_ff[i];
         end

         assign cell_in[i] = !apply ? cell_ff[i] : (is_delete ? del_val : ins_val);

         always_ff @(posedge clock) begin
            if (reset) begin
               cell_ff[i] <= '0;
            end else begin
               cell_ff[i] <= cell_in[i];
            end
         end
      end
   endgenerate

   always_comb begin
      count_in = count_ff;
      if (apply) begin
         count_in = is_delete ? (count_ff - CW'(1)) : (count_ff + CW'(1));
      end
   end

   assign count_wide = {{stq_pkg::COUNT_OUT_W{1'b0}}, count_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         func_ff <= req_func;
         time_ff <= req_time_value;
      end
      if (cmd.compare) begin
         lt_ff <= lt_in;
         eq_ff <= eq_in;
      end
      if (cmd.commit) begin
         rsp_status_ff   <= cmd.result;
         rsp_count_ff    <= count_wide[stq_pkg::COUNT_OUT_W-1:0];
         rsp_earliest_ff <= cell_in[0];
      end
   end

   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_earliest    = rsp_earliest_ff;

endmodule

`default_nettype wire

// ===== rtl/core/sorted_timer_queue_core.sv =====
// ----------------------------------------------------------------------------
// Sorted timer queue core
// Bounded queue of nonzero timer values kept in ascending order.
// ----------------------------------------------------------------------------
// Usage:
// A request carries req_func (insert or delete) and req_time_value. Insert
// places the value ahead of equal entries; delete removes the first equal
// entry. A zero value is ignored, and an insert into a full queue is refused.
// Every request yields one response with a status, the entry count after the
// operation, and the earliest stored value (zero when empty).
// A request is taken in the idle state; the next cycle registers the cell
// compares, and the shift step then shifts the cell chain, loads the response
// register and raises rsp_valid once that register is free. The core takes
// a new request only after the last one has passed the accept, compare and
// shift steps of the controller. If the receiver stalls, the response register
// holds its value and the core still accepts the next request, holding it in
// the shift step until the response register frees up.
// Reset empties the queue at once; the core is ready in the first cycle after.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_timer_queue_core #(
   parameter int DEPTH = 16
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output      logic                            req_ready,
   input  wire logic                            req_func,
   input  wire logic [stq_pkg::TIME_W-1:0]      req_time_value,
   output      logic                            rsp_valid,
   input  wire logic                            rsp_ready,
   output      logic [stq_pkg::STATUS_W-1:0]    rsp_status,
   output      logic [stq_pkg::COUNT_OUT_W-1:0] rsp_entry_count,
   output      logic [stq_pkg::TIME_W-1:0]      rsp_earliest
);

`include "sorted_timer_queue_core_assert.svh"

   localparam logic [stq_pkg::COUNT_OUT_W-1:0] DEPTH_OUT =
      stq_pkg::COUNT_OUT_W'(DEPTH);

   stq_pkg::dp_cmd_type    cmd;
   stq_pkg::dp_status_type dp_status;

   stq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .dp_status (dp_status)
   );

   stq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_func        (req_func),
      .req_time_value  (req_time_value),
      .cmd             (cmd),
      .dp_status       (dp_status),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count),
      .rsp_earliest    (rsp_earliest)
   );

   `STQ_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "core ready again right after accepting a request")

   `STQ_ASSERT_SAME(a_commit_needs_room, clock, reset, cmd.commit, !rsp_valid || rsp_ready, "response register overwritten while still held")

   `STQ_ASSERT_SAME(a_full_count, clock, reset, rsp_valid && (rsp_status == stq_pkg::STATUS_FULL), rsp_entry_count == DEPTH_OUT, "full status reported with a count other than the depth")

endmodule

`default_nettype wire
